@@ hdl/ntaf_pkg.sv @@
// Shared types, constants and helpers for the number-to-ASCII formatter.
// Used by the front end, the job queue, the character emitter and the top level.
// No dependencies.
`default_nettype none

package ntaf_pkg;

  // Widths of the item fields and of the job record
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned DIGITS_W = 80;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned PP_W     = 5;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned CHAR_W   = 7;

  // Action codes on the input beat
  localparam logic [ACT_W-1:0] ACT_DEC   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POINT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_HEX   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GROUP = 3'd3;
  localparam logic [ACT_W-1:0] ACT_BYTE  = 3'd4;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CH_LETTER = 7'h37;
  localparam logic [CHAR_W-1:0] CH_POINT  = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_APOS   = 7'h27;

  // Digit positions followed by an apostrophe in grouped hex
  localparam logic [IDX_W-1:0] GROUP_HI  = 5'd12;
  localparam logic [IDX_W-1:0] GROUP_MID = 5'd8;
  localparam logic [IDX_W-1:0] GROUP_LO  = 5'd4;

  // Highest nibble index of the value and of the low byte
  localparam logic [IDX_W-1:0] TOP_NIBBLE = 5'd15;
  localparam logic [IDX_W-1:0] TOP_BYTE   = 5'd1;

  // How the emitter places separators between the digits
  typedef enum logic [1:0] {
    K_PLAIN,
    K_POINT,
    K_GROUP
  } kind_t;

  // One formatting job: digits as nibbles, emitted from index top down to 0
  typedef struct packed {
    kind_t               kind;
    logic [DIGITS_W-1:0] digits;
    logic [IDX_W-1:0]    top;
    logic [PP_W-1:0]     pp;
  } job_t;

  // ASCII for one decimal or hex digit, hex letters in upper case
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    return (d < 4'd10) ? CH_ZERO + CHAR_W'(d) : CH_LETTER + CHAR_W'(d);
  endfunction

endpackage

`default_nettype wire

@@ hdl/number_to_ascii_formatter_unit.sv @@
// Top level of the number-to-ASCII formatter: front end, job queue and emitter.
// Depends on ntaf_pkg, ntaf_front, ntaf_queue and ntaf_back.
//
// Channel  | Direction | Beat contents
// s_axis   | in        | tdata: action[2:0], value[66:3], frac_digits[71:67]
// m_axis   | out       | tdata: character[6:0], zero in bit 7; tlast: last
//
// A beat is taken only while the front end is idle; decimal formats then run the shift-and-add-3
// loop over all 64 value bits before handing the job over, and hex formats go straight to the
// hand-over. The emitter then sends one character per cycle while m_axis is ready,
// loading each job from the queue before its first character.
// A two-entry queue decouples the two; a long m_axis stall fills it and then holds s_axis.
// Reset clears all control state at once; actions 5 to 7 are taken and produce no text.
`default_nettype none

module number_to_ascii_formatter_unit #(
  parameter int unsigned MAX_DIGITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // action[2:0], value[66:3], frac_digits[71:67]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // character[6:0], bit 7 zero
  output logic             m_tlast
);
  import ntaf_pkg::*;

  logic push_valid;
  logic push_ready;
  job_t push_data;
  logic pop_valid;
  logic pop_ready;
  job_t pop_data;

  // Accept and convert
  ntaf_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_action  (s_tdata[2:0]),
    .in_value   (s_tdata[66:3]),
    .in_pp      (s_tdata[71:67]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple conversion from emission
  ntaf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Emit characters
  ntaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire

@@ hdl/ntaf_front.sv @@
// Front end: accepts input beats, converts decimal values to BCD by shift-and-add-3,
// finds the leading digit and hands a finished job to the queue.
// Depends on ntaf_pkg.
`default_nettype none

module ntaf_front #(
  parameter int unsigned MAX_DIGITS = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ntaf_pkg::ACT_W-1:0]    in_action,
  input  wire logic [ntaf_pkg::VALUE_W-1:0]  in_value,
  input  wire logic [ntaf_pkg::PP_W-1:0]     in_pp,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output ntaf_pkg::job_t                     push_data
);
  import ntaf_pkg::*;

  localparam int unsigned BCD_W = 4 * MAX_DIGITS;
  localparam logic [5:0]  LAST_STEP = 6'(VALUE_W - 1);
  localparam logic [PP_W-1:0] PP_MAX = PP_W'(MAX_DIGITS - 1);
  localparam logic [IDX_W-1:0] DEC_TOP_MAX = IDX_W'(MAX_DIGITS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_PUSH
  } state_t;

  state_t             state;
  logic [ACT_W-1:0]   action;
  logic [VALUE_W-1:0] value;
  logic [PP_W-1:0]    pp;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_next;
  logic               bcd_carry;
  logic               ovf;
  logic [5:0]         step;
  logic [IDX_W-1:0]   dec_top;
  logic [IDX_W-1:0]   hex_top;
  logic [PP_W-1:0]    pp_sat;

  // One double-dabble step: correct every digit of five or more, then shift in.
  // The bit shifted out of the top digit means the value no longer fits the buffer.
  always_comb begin
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < int'(MAX_DIGITS); i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    bcd_next  = {adj[BCD_W-2:0], value[VALUE_W-1]};
    bcd_carry = adj[BCD_W-1];
  end

  // Leading digit of the decimal and of the hex form; zero counts as one digit.
  // A value too wide for the buffer keeps every buffer digit, zeros included.
  always_comb begin
    dec_top = '0;
    for (int i = 0; i < int'(MAX_DIGITS); i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        dec_top = IDX_W'(i);
      end
    end
    if (ovf) begin
      dec_top = DEC_TOP_MAX;
    end
    hex_top = '0;
    for (int i = 0; i < 16; i++) begin
      if (value[4*i +: 4] != 4'd0) begin
        hex_top = IDX_W'(i);
      end
    end
    pp_sat = (pp > PP_MAX) ? PP_MAX : pp;
  end

  // Build the job record from the finished conversion
  always_comb begin
    push_data        = '0;
    push_data.kind   = K_PLAIN;
    push_data.digits = DIGITS_W'(value);
    push_data.top    = hex_top;
    push_data.pp     = pp_sat;
    unique case (action)
      ACT_DEC: begin
        push_data.digits = DIGITS_W'(bcd);
        push_data.top    = dec_top;
      end
      ACT_POINT: begin
        push_data.kind   = K_POINT;
        push_data.digits = DIGITS_W'(bcd);
        push_data.top    = (dec_top > pp_sat) ? dec_top : pp_sat;
      end
      ACT_GROUP: begin
        push_data.kind = K_GROUP;
        push_data.top  = TOP_NIBBLE;
      end
      ACT_BYTE: begin
        push_data.top = TOP_BYTE;
      end
      default: begin
        push_data.top = hex_top;
      end
    endcase
  end

  assign in_ready   = (state == S_IDLE);
  assign push_valid = (state == S_PUSH);

  // Sequencer: idle, 64 conversion steps for decimal, then hand-over
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            action <= in_action;
            value  <= in_value;
            pp     <= in_pp;
            bcd    <= '0;
            ovf    <= 1'b0;
            step   <= '0;
            case (in_action) inside
              ACT_DEC, ACT_POINT:            state <= S_CONV;
              ACT_HEX, ACT_GROUP, ACT_BYTE:  state <= S_PUSH;
              default:                       state <= S_IDLE;
            endcase
          end
        end
        S_CONV: begin
          bcd   <= bcd_next;
          value <= {value[VALUE_W-2:0], 1'b0};
          step  <= step + 6'd1;
          if (bcd_carry) begin
            ovf <= 1'b1;
          end
          if (step == LAST_STEP) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The conversion always ends after exactly one step per value bit
  a_conv_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV && step == LAST_STEP) |=> (state == S_PUSH))
    else $error("conversion did not finish after the last step");

  // A job offered to the queue stays offered until taken
  a_push_hold: assert property (@(posedge clk) disable iff (rst)
    (push_valid && !push_ready) |=> push_valid)
    else $error("job withdrawn before the queue took it");

endmodule

`default_nettype wire

@@ hdl/ntaf_queue.sv @@
// Two-entry job queue between the front end and the character emitter.
// Depends on ntaf_pkg.
`default_nettype none

module ntaf_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire ntaf_pkg::job_t  push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output ntaf_pkg::job_t       pop_data
);
  import ntaf_pkg::*;

  localparam int unsigned DEPTH = 2;

  job_t       mem [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'(DEPTH));
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_level: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH))
    else $error("queue fill level beyond its depth");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count != 2'd0))
    else $error("queue empty after a push");

endmodule

`default_nettype wire

@@ hdl/ntaf_back.sv @@
// Character emitter: takes jobs from the queue and sends one character per beat,
// placing the decimal point or the group apostrophes and flagging the last one.
// Depends on ntaf_pkg.
`default_nettype none

module ntaf_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire ntaf_pkg::job_t  pop_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_data,
  output logic                 out_last
);
  import ntaf_pkg::*;

  job_t              job;
  logic              active;
  logic              sep;
  logic [IDX_W-1:0]  k;
  logic [3:0]        cur_digit;
  logic              need_sep;
  logic              adv;
  logic              emit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic              pop;

  assign pop_ready = !active;
  assign pop       = pop_valid && pop_ready;

  // Choose the next character and whether a separator follows this digit
  always_comb begin
    cur_digit = job.digits[{k, 2'b00} +: 4];
    need_sep  = (job.kind == K_POINT && k == job.pp) ||
                (job.kind == K_GROUP &&
                 (k == GROUP_HI || k == GROUP_MID || k == GROUP_LO));
    adv  = !out_valid || out_ready;
    emit = active && adv;
    if (sep) begin
      emit_char = (job.kind == K_POINT) ? CH_POINT : CH_APOS;
      emit_last = (k == '0);
    end else begin
      emit_char = digit_char(cur_digit);
      emit_last = (k == '0) && !need_sep;
    end
  end

  // Walk the digits from the top down; the output register parts the two sides
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      sep       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= emit;
      end
      if (emit) begin
        out_data <= {1'b0, emit_char};
        out_last <= emit_last;
        if (!sep && need_sep) begin
          sep <= 1'b1;
        end else begin
          sep <= 1'b0;
          if (k == '0) begin
            active <= 1'b0;
          end else begin
            k <= k - 5'd1;
          end
        end
      end else if (pop) begin
        active <= 1'b1;
        job    <= pop_data;
        k      <= pop_data.top;
        sep    <= 1'b0;
      end
    end
  end

  // The final character of a job always closes that job
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last) |=> !active)
    else $error("job still active after its last character");

  // Only point and grouped formats ever produce a separator
  a_sep_kind: assert property (@(posedge clk) disable iff (rst)
    (active && sep) |-> (job.kind != K_PLAIN))
    else $error("separator in a plain format");

endmodule

`default_nettype wire

@@ test/ntaf_checker.sv @@
// Checker for the number-to-ASCII formatter: watches both stream channels,
// predicts the text of every accepted value and compares it beat by beat.
// Depends on ntaf_pkg for the action and character codes.
module ntaf_checker
  import ntaf_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,   // action[2:0], value[66:3], frac_digits[71:67]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // character[6:0], bit 7 zero
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CHAR_W-1:0] GLYPH_A = 7'h41;

  // One expected output beat
  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } glyph_t;

  glyph_t text_due[$];
  int     mismatch_count;

  function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + {3'b000, nib};
    return GLYPH_A - 7'd10 + {3'b000, nib};
  endfunction

  // Work out the characters for one input beat and queue them, last one flagged.
  function automatic void render_number(input logic [ACT_W-1:0] act,
                                        input logic [VALUE_W-1:0] val,
                                        input logic [PP_W-1:0] pp);
    logic [3:0]        digs [MAX_DIGITS];
    logic [CHAR_W-1:0] line [$];
    logic [VALUE_W-1:0] rest;
    int                point;
    int                n;
    int                i;
    glyph_t            g;
    case (act)
      ACT_DEC, ACT_POINT: begin
        // Point position saturates at the top of the digit buffer.
        point = -1;
        if (act == ACT_POINT) point = (pp > MAX_DIGITS - 1) ? MAX_DIGITS - 1 : pp;
        rest = val;
        n = 0;
        while (n < point) begin
          digs[n] = 4'(rest % 10);
          rest = rest / 10;
          n++;
        end
        // At least one more digit, then on while anything is left.
        do begin
          digs[n] = 4'(rest % 10);
          rest = rest / 10;
          n++;
        end while (n < MAX_DIGITS && rest != 0);
        for (i = n - 1; i >= 0; i--) begin
          line.push_back(CH_ZERO + {3'b000, digs[i]});
          if (i == point) line.push_back(CH_POINT);
        end
      end
      ACT_HEX: begin
        i = 15;
        while (i > 0 && val[4*i +: 4] == 4'h0) i--;
        for (; i >= 0; i--) line.push_back(hex_glyph(val[4*i +: 4]));
      end
      ACT_GROUP: begin
        for (i = 15; i >= 0; i--) begin
          if (i == 11 || i == 7 || i == 3) line.push_back(CH_APOS);
          line.push_back(hex_glyph(val[4*i +: 4]));
        end
      end
      ACT_BYTE: begin
        line.push_back(hex_glyph(val[7:4]));
        line.push_back(hex_glyph(val[3:0]));
      end
      default: begin
        // Spare actions produce no text at all.
      end
    endcase
    for (i = 0; i < line.size(); i++) begin
      g.code = line[i];
      g.last = (i == line.size() - 1);
      text_due.push_back(g);
    end
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: mismatch on %s, expected %h, got %h", $time, what, want, got);
  endtask

  // Compare each output beat with the oldest expectation, then log new input.
  always @(posedge clk) begin
    glyph_t due;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (text_due.size() == 0) begin
          note_mismatch("unexpected beat", 0, m_tdata);
        end else begin
          due = text_due.pop_front();
          if (m_tdata[CHAR_W-1:0] !== due.code)
            note_mismatch("character", due.code, m_tdata[CHAR_W-1:0]);
          if (m_tlast !== due.last)
            note_mismatch("last flag", due.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready)
        render_number(s_tdata[2:0], s_tdata[66:3], s_tdata[71:67]);
    end
    pending <= text_due.size();
    errors  <= mismatch_count;
  end

endmodule

@@ test/tb_top.sv @@
// Top of the formatter testbench: clock, reset, directed and random values,
// random stalls on both channels and the final verdict.
// Depends on ntaf_pkg, number_to_ascii_formatter_unit and ntaf_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ntaf_pkg::*;

  localparam int unsigned    DIGITS      = 20;
  localparam int             RANDOM_RUNS = 250;
  localparam int             CALM_TAIL   = 40;
  localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_MID   = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;
  localparam logic [VALUE_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        calm = 1'b0;
  int          errors;
  int          pending;

  number_to_ascii_formatter_unit #(.MAX_DIGITS(DIGITS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  ntaf_checker #(.MAX_DIGITS(DIGITS)) text_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #15_000_000;
    $display("FAILURE");
    $finish;
  end

  // Offer one beat, after an optional random gap, and hold it until taken.
  task automatic feed(input logic [ACT_W-1:0] act, input logic [VALUE_W-1:0] val,
                      input logic [PP_W-1:0] pp);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tdata  <= {pp, val, act};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Values with a spread of magnitudes, including the edges of each digit count.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] p;
    p = 64'd1;
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return VALUE_W'($urandom_range(0, 20));
      2: return {$urandom, $urandom} >> $urandom_range(0, 63);
      3: begin
        repeat ($urandom_range(0, 19)) p = p * 10;
        return p + $urandom_range(0, 2) - 1;
      end
      default: return 64'd1 << $urandom_range(0, 63);
    endcase
  endfunction

  // Output side: ready in random stretches broken by short stalls.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    logic [ACT_W-1:0] modes [5];
    logic [ACT_W-1:0] act;
    logic [PP_W-1:0]  pp;
    modes = '{ACT_DEC, ACT_POINT, ACT_HEX, ACT_GROUP, ACT_BYTE};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of every format, point placement and saturation.
    feed(ACT_DEC, 64'd0, 5'd0);
    feed(ACT_DEC, 64'd1, 5'd31);
    feed(ACT_DEC, ALL_ONES, 5'd0);
    feed(ACT_DEC, 64'd10000000000000000000, 5'd0);
    feed(ACT_POINT, 64'd5, 5'd0);
    feed(ACT_POINT, 64'd1, 5'd1);
    feed(ACT_POINT, 64'd1234, 5'd2);
    feed(ACT_POINT, 64'd0, 5'd0);
    feed(ACT_POINT, ALL_ONES, 5'd19);
    feed(ACT_POINT, ALL_ONES, 5'd31);
    feed(ACT_POINT, 64'd7, 5'd20);
    feed(ACT_POINT, 64'd0, 5'd19);
    feed(ACT_HEX, 64'd0, 5'd0);
    feed(ACT_HEX, ALL_ONES, 5'd31);
    feed(ACT_HEX, 64'h10, 5'd0);
    feed(ACT_HEX, 64'h8000_0000_0000_0000, 5'd0);
    feed(ACT_GROUP, 64'd0, 5'd0);
    feed(ACT_GROUP, ALL_ONES, 5'd0);
    feed(ACT_GROUP, 64'h0123_4567_89AB_CDEF, 5'd0);
    feed(ACT_BYTE, 64'd0, 5'd0);
    feed(ACT_BYTE, ALL_ONES, 5'd31);
    feed(ACT_BYTE, 64'h1234_5678_9ABC_DEA5, 5'd0);
    feed(ACT_SPARE_FIRST, ALL_ONES, 5'd31);
    feed(ACT_SPARE_MID, 64'd42, 5'd3);
    feed(ACT_SPARE_LAST, 64'd0, 5'd0);

    // Random: mostly known formats, a few spare actions, wide point positions.
    for (int k = 0; k < RANDOM_RUNS; k++) begin
      if (k == RANDOM_RUNS / 2) begin
        // Let the output drain completely before going on; wait on the clock first so that
        // the count already holds the text of the beat just taken.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (k == RANDOM_RUNS - CALM_TAIL) calm <= 1'b1;
      if ($urandom_range(0, 99) < 8) begin
        act = ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
      end else begin
        act = modes[$urandom_range(0, 4)];
      end
      if ($urandom_range(0, 9) < 8) pp = PP_W'($urandom_range(0, 19));
      else pp = PP_W'($urandom_range(20, 31));
      feed(act, pick_value(), pp);
    end
    s_tvalid <= 1'b0;

    // Wait for the text to drain, then a little longer for stray beats.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
